[hw/rtl/jsu_pkg.sv]
// ----------------------------------------------------------------------------
// JSON string unescape package
// Shared result codes and the record types passed between the decode and
// emit stages.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

  // Number of result bytes one input byte can cause (a three-byte UTF-8 form).
  localparam int unsigned MaxResults = 3;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_DATA  = 3'd0,
    ST_DONE  = 3'd1,
    ST_BADCH = 3'd2,
    ST_END   = 3'd3,
    ST_CTRL  = 3'd4
  } status_e;

  // One result item.
  typedef struct packed {
    logic [7:0] out_byte;
    status_e    status;
    logic       last;
  } result_t;

  // Results caused by one input byte, handed from decode to emit.
  typedef struct packed {
    logic                 fire;
    logic [1:0]           count;
    result_t [MaxResults-1:0] res;
  } group_t;

endpackage

`default_nettype wire

[hw/rtl/jsu_in_if.sv]
// ----------------------------------------------------------------------------
// JSON text input channel
// Valid/ready channel carrying one raw text byte and an end-of-input flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

`default_nettype wire

[hw/rtl/jsu_out_if.sv]
// ----------------------------------------------------------------------------
// Decoded string output channel
// Valid/ready channel carrying one decoded byte, its status and a last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] status;
  logic       last;

  modport source (output valid, output out_byte, output status, output last, input ready);
  modport sink   (input valid, input out_byte, input status, input last, output ready);
endinterface

`default_nettype wire

[hw/rtl/jsu_decode.sv]
// ----------------------------------------------------------------------------
// JSON string unescape decode stage
// Registers the incoming byte, tracks the string phase and hex accumulator,
// and computes all results for the registered byte in one pass.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_decode (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  jsu_in_if.sink              in_i,
  input  wire logic           take_i,
  output jsu_pkg::group_t     grp_o
);

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_STR  = 3'd1,
    PH_ESC  = 3'd2,
    PH_HEX1 = 3'd3,
    PH_HEX2 = 3'd4,
    PH_HEX3 = 3'd5,
    PH_HEX4 = 3'd6
  } phase_e;

  // ASCII characters of interest.
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBack  = 8'h5C;
  localparam logic [7:0] ChSlash = 8'h2F;

  logic       vld_q;
  logic [7:0] byte_q;
  logic       eoi_q;
  phase_e     phase_q, phase_d;
  logic [15:0] acc_q, acc_d;
  logic       fire;

  logic [4:0]  hex_val;
  logic [15:0] cp;
  jsu_pkg::group_t grp;

  // Hex digit decode: bit 4 flags a valid digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, c[3:0]};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, c[3:0] + 4'd9};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, c[3:0] + 4'd9};
    return r;
  endfunction

  function automatic jsu_pkg::result_t mk(input logic [7:0] b,
                                          input jsu_pkg::status_e st,
                                          input logic l);
    jsu_pkg::result_t r;
    r.out_byte = b;
    r.status   = st;
    r.last     = l;
    return r;
  endfunction

  // The input register frees when its byte moves into the emit stage.
  assign fire       = vld_q && take_i;
  assign in_i.ready = !vld_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= 1'b0;
      phase_q <= PH_IDLE;
      acc_q   <= 16'd0;
    end else begin
      if (in_i.ready) begin
        vld_q <= in_i.valid;
      end
      if (fire) begin
        phase_q <= phase_d;
        acc_q   <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q <= in_i.in_byte;
      eoi_q  <= in_i.end_of_input;
    end
  end

  assign hex_val = hex_digit(byte_q);
  assign cp      = {acc_q[11:0], hex_val[3:0]};

  // Next state and results for the registered byte.
  always_comb begin
    phase_d    = phase_q;
    acc_d      = acc_q;
    grp.fire   = fire;
    grp.count  = 2'd0;
    grp.res[0] = mk(8'd0, jsu_pkg::ST_DATA, 1'b1);
    grp.res[1] = mk(8'd0, jsu_pkg::ST_DATA, 1'b1);
    grp.res[2] = mk(8'd0, jsu_pkg::ST_DATA, 1'b1);
    if (eoi_q) begin
      phase_d    = PH_IDLE;
      acc_d      = 16'd0;
      grp.count  = 2'd1;
      grp.res[0] = mk(8'd0, jsu_pkg::ST_END, 1'b1);
    end else begin
      unique case (phase_q)
        PH_STR: begin
          if (byte_q == ChQuote) begin
            phase_d    = PH_IDLE;
            grp.count  = 2'd1;
            grp.res[0] = mk(8'd0, jsu_pkg::ST_DONE, 1'b1);
          end else if (byte_q == ChBack) begin
            phase_d = PH_ESC;
          end else if (byte_q < 8'h20 || byte_q == 8'h7F) begin
            phase_d    = PH_IDLE;
            acc_d      = 16'd0;
            grp.count  = 2'd1;
            grp.res[0] = mk(8'd0, jsu_pkg::ST_CTRL, 1'b1);
          end else begin
            grp.count  = 2'd1;
            grp.res[0] = mk(byte_q, jsu_pkg::ST_DATA, 1'b1);
          end
        end
        PH_ESC: begin
          grp.count = 2'd1;
          phase_d   = PH_STR;
          unique case (byte_q)
            ChQuote, ChBack, ChSlash: grp.res[0] = mk(byte_q, jsu_pkg::ST_DATA, 1'b1);
            8'h62:   grp.res[0] = mk(8'h08, jsu_pkg::ST_DATA, 1'b1);
            8'h66:   grp.res[0] = mk(8'h0C, jsu_pkg::ST_DATA, 1'b1);
            8'h6E:   grp.res[0] = mk(8'h0A, jsu_pkg::ST_DATA, 1'b1);
            8'h72:   grp.res[0] = mk(8'h0D, jsu_pkg::ST_DATA, 1'b1);
            8'h74:   grp.res[0] = mk(8'h09, jsu_pkg::ST_DATA, 1'b1);
            8'h75: begin
              phase_d   = PH_HEX1;
              acc_d     = 16'd0;
              grp.count = 2'd0;
            end
            default: begin
              phase_d    = PH_IDLE;
              acc_d      = 16'd0;
              grp.res[0] = mk(8'd0, jsu_pkg::ST_BADCH, 1'b1);
            end
          endcase
        end
        PH_HEX1, PH_HEX2, PH_HEX3, PH_HEX4: begin
          if (!hex_val[4]) begin
            phase_d    = PH_IDLE;
            acc_d      = 16'd0;
            grp.count  = 2'd1;
            grp.res[0] = mk(8'd0, jsu_pkg::ST_BADCH, 1'b1);
          end else if (phase_q != PH_HEX4) begin
            acc_d   = cp;
            phase_d = phase_e'(phase_q + 3'd1);
          end else begin
            // Fourth digit: encode the code unit as UTF-8.
            acc_d   = cp;
            phase_d = PH_STR;
            if (cp <= 16'h007F) begin
              grp.count  = 2'd1;
              grp.res[0] = mk(cp[7:0], jsu_pkg::ST_DATA, 1'b1);
            end else if (cp <= 16'h07FF) begin
              grp.count  = 2'd2;
              grp.res[0] = mk({3'b110, cp[10:6]}, jsu_pkg::ST_DATA, 1'b0);
              grp.res[1] = mk({2'b10, cp[5:0]}, jsu_pkg::ST_DATA, 1'b1);
            end else begin
              grp.count  = 2'd3;
              grp.res[0] = mk({4'b1110, cp[15:12]}, jsu_pkg::ST_DATA, 1'b0);
              grp.res[1] = mk({2'b10, cp[11:6]}, jsu_pkg::ST_DATA, 1'b0);
              grp.res[2] = mk({2'b10, cp[5:0]}, jsu_pkg::ST_DATA, 1'b1);
            end
          end
        end
        default: begin
          // Idle, and the unused phase code, wait for the opening quote.
          if (byte_q == ChQuote) begin
            phase_d = PH_STR;
          end else begin
            phase_d    = PH_IDLE;
            acc_d      = 16'd0;
            grp.count  = 2'd1;
            grp.res[0] = mk(8'd0, jsu_pkg::ST_BADCH, 1'b1);
          end
        end
      endcase
    end
  end

  assign grp_o = grp;

endmodule

`default_nettype wire

[hw/rtl/jsu_emit.sv]
// ----------------------------------------------------------------------------
// JSON string unescape emit stage
// Holds the results of one decoded byte and presents them one per request
// on the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_emit (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire jsu_pkg::group_t grp_i,
  output logic                 take_o,
  jsu_out_if.source            out_o
);

  jsu_pkg::result_t [jsu_pkg::MaxResults-1:0] res_q;
  logic [1:0] cnt_q;
  logic [1:0] idx_q;
  logic       pop;
  jsu_pkg::result_t cur;

  assign cur  = res_q[idx_q];
  assign pop  = out_o.valid && out_o.ready;
  // A new group may land once the last held result leaves.
  assign take_o = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      idx_q <= 2'd0;
    end else begin
      if (grp_i.fire && grp_i.count != 2'd0) begin
        cnt_q <= grp_i.count;
        idx_q <= 2'd0;
      end else if (pop) begin
        cnt_q <= cnt_q - 2'd1;
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (grp_i.fire && grp_i.count != 2'd0) begin
      res_q <= grp_i.res;
    end
  end

  assign out_o.valid    = (cnt_q != 2'd0);
  assign out_o.out_byte = cur.out_byte;
  assign out_o.status   = cur.status;
  assign out_o.last     = cur.last;

endmodule

`default_nettype wire

[hw/rtl/json_string_unescape_utf8.sv]
// ----------------------------------------------------------------------------
// JSON string unescape to UTF-8
// Decodes a JSON string literal byte stream, with escapes and \u code
// units, into UTF-8 bytes with a status code on each result.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload                         Handshake
//  in_i     in   in_byte[7:0], end_of_input      valid/ready
//  out_o    out  out_byte[7:0], status[2:0], last valid/ready
//
//  One input byte is taken per cycle while each byte yields at most one result
//  and the output is ready. A \u escape ending in a code unit above 0x7F yields
//  two or three results, sent one per cycle from the emit buffer while the
//  output is ready, so the input waits until the last of them is being sent.
//  The first result is valid once its byte has moved on into the emit buffer.
//  Reset returns to idle (awaiting the opening quote) with no results pending.
//  Output stalls back up through the emit buffer and the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescape_utf8 (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  jsu_in_if.sink     in_i,
  jsu_out_if.source  out_o
);

  jsu_pkg::group_t grp;
  logic            take;

  // Input register, phase tracking and single-pass decode.
  jsu_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .take_i (take),
    .grp_o  (grp)
  );

  // Result buffer that serializes multi-byte results.
  jsu_emit u_emit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .grp_i  (grp),
    .take_o (take),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire
